// ===== sv/mandelbrot_escape_count_assert.svh =====
// Assertion macros for the escape-count block
`ifndef MANDELBROT_ESCAPE_COUNT_ASSERT_SVH
`define MANDELBROT_ESCAPE_COUNT_ASSERT_SVH

`define MEC_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
    else $error("escape count check failed");

`define MEC_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
    else $error("escape count sequence check failed");

`endif

// ===== sv/mec_pkg.sv =====
// Shared types and constants for the escape-count block
package mec_pkg;

  localparam int DATA_W       = 16;
  localparam int Z_W          = 18;
  localparam int PROD_W       = 2 * Z_W;
  localparam int SQ_SHIFT     = 13;
  localparam int CROSS_SHIFT  = 12;
  localparam int SQ_W         = PROD_W - SQ_SHIFT;
  localparam int XP_W         = PROD_W - CROSS_SHIFT;
  localparam int SUM_W        = SQ_W + 2;
  localparam int COUNT_W      = 8;
  localparam int NUM_CELLS    = 4;
  localparam int ESCAPE_BOUND = 32768;

  localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(40);

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_ITER_LIMIT = 1'b0;

  typedef struct packed {
    logic signed [DATA_W-1:0] c_real;
    logic signed [DATA_W-1:0] c_imag;
  } in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] iteration_count;
    logic               inside_set;
  } out_t;

  typedef struct packed {
    logic                     valid;
    logic                     done;
    logic                     in_set;
    logic [COUNT_W-1:0]       count;
    logic signed [Z_W-1:0]    re;
    logic signed [Z_W-1:0]    im;
    logic signed [DATA_W-1:0] cr;
    logic signed [DATA_W-1:0] ci;
  } cell_t;

endpackage

// ===== sv/mandelbrot_escape_count.sv =====
// Mandelbrot escape-time counter: a ring of iteration cells, one point at a time.
// A point circulates through the cells until it escapes or reaches the limit; its result
//   is then registered and out_valid_o rises.
// A new input is accepted only after the previous point's result loads, and a stalled
//   output holds the ring.
`include "mandelbrot_escape_count_assert.svh"

module mandelbrot_escape_count
  import mec_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_t               out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [COUNT_W-1:0]   limit;
  cell_t                chain [NUM_CELLS+1];
  cell_t                tail;
  cell_t                ring_in;
  logic [NUM_CELLS-1:0] cell_valid;
  logic                 in_xfer;
  logic                 tail_take;
  logic                 advance;
  logic                 busy_q;
  logic                 out_valid_q;
  out_t                 out_q;

  mec_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limit_o (limit)
  );

  assign tail      = chain[NUM_CELLS];
  assign in_stall_o = busy_q;
  assign in_xfer   = in_valid_i && !busy_q;
  assign tail_take = tail.valid && tail.done;
  assign advance   = !(tail_take && out_valid_q && out_stall_i);

  always_comb begin
    ring_in = '0;
    if (in_xfer) begin
      ring_in.valid = 1'b1;
      ring_in.re    = Z_W'(in_data_i.c_real);
      ring_in.im    = Z_W'(in_data_i.c_imag);
      ring_in.cr    = in_data_i.c_real;
      ring_in.ci    = in_data_i.c_imag;
    end else if (tail.valid && !tail.done) begin
      ring_in = tail;
    end
  end

  assign chain[0] = ring_in;

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    mec_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .limit_i   (limit),
      .cell_i    (chain[k]),
      .cell_o    (chain[k+1])
    );
    assign cell_valid[k] = chain[k+1].valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (in_xfer) begin
        busy_q <= 1'b1;
      end else if (tail_take && advance) begin
        busy_q <= 1'b0;
      end
      if (tail_take && advance) begin
        out_valid_q           <= 1'b1;
        out_q.iteration_count <= tail.count;
        out_q.inside_set      <= tail.in_set;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `MEC_ASSERT_IMPLIES(a_one_point_in_ring, clk_i, rst_ni, 1'b1, $onehot0(cell_valid))
  `MEC_ASSERT_IMPLIES(a_idle_ring_empty, clk_i, rst_ni, !busy_q, cell_valid == '0)
  `MEC_ASSERT_NEXT(a_accept_sets_busy, clk_i, rst_ni, in_xfer, busy_q)
  `MEC_ASSERT_IMPLIES(a_inside_at_limit, clk_i, rst_ni, out_valid_q && out_q.inside_set,
                      out_q.iteration_count == limit)

endmodule

// ===== sv/mec_cfg.sv =====
// APB register holding the iteration limit
module mec_cfg
  import mec_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PADDR_W-1:0]        paddr,
  input  logic [PDATA_W-1:0]        pwdata,
  output logic [PDATA_W-1:0]        prdata,
  output logic                      pready,
  output logic [COUNT_W-1:0]        limit_o
);

  logic               reg_idx;
  logic               wr_en;
  logic [COUNT_W-1:0] limit_q;

  assign reg_idx = paddr[PADDR_W-1];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready && (reg_idx == REG_ITER_LIMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (wr_en) begin
      limit_q <= pwdata[COUNT_W-1:0];
    end
  end

  assign prdata  = (reg_idx == REG_ITER_LIMIT) ? PDATA_W'(limit_q) : '0;
  assign limit_o = limit_q;

endmodule

// ===== sv/mec_cell.sv =====
// One iteration cell: limit and escape tests and z = z*z + c, handed to the next cell
module mec_cell
  import mec_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               advance_i,
  input  logic [COUNT_W-1:0] limit_i,
  input  cell_t              cell_i,
  output cell_t              cell_o
);

  logic signed [PROD_W-1:0] rr;
  logic signed [PROD_W-1:0] ii;
  logic signed [PROD_W-1:0] ri;
  logic [SQ_W-1:0]          rq;
  logic [SQ_W-1:0]          iq;
  logic [SQ_W:0]            mag;
  logic signed [SUM_W-1:0]  re_sum;
  logic signed [SUM_W-1:0]  im_sum;
  logic                     escape;
  logic                     at_limit;
  cell_t                    state_d;
  cell_t                    state_q;

  assign rr = cell_i.re * cell_i.re;
  assign ii = cell_i.im * cell_i.im;
  assign ri = cell_i.re * cell_i.im;

  assign rq  = rr[PROD_W-1:SQ_SHIFT];
  assign iq  = ii[PROD_W-1:SQ_SHIFT];
  assign mag = {1'b0, rq} + {1'b0, iq};

  assign escape   = mag > (SQ_W+1)'(ESCAPE_BOUND);
  assign at_limit = cell_i.count >= limit_i;

  assign re_sum = $signed({2'b00, rq}) - $signed({2'b00, iq}) + SUM_W'(cell_i.cr);
  assign im_sum = SUM_W'($signed(ri[PROD_W-1:CROSS_SHIFT])) + SUM_W'(cell_i.ci);

  always_comb begin
    state_d = cell_i;
    if (cell_i.valid && !cell_i.done) begin
      priority if (at_limit) begin
        state_d.done   = 1'b1;
        state_d.in_set = 1'b1;
      end else if (escape) begin
        state_d.done   = 1'b1;
        state_d.in_set = 1'b0;
      end else begin
        state_d.re    = re_sum[Z_W-1:0];
        state_d.im    = im_sum[Z_W-1:0];
        state_d.count = cell_i.count + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance_i) begin
      state_q <= state_d;
    end
  end

  assign cell_o = state_q;

endmodule
